FILE: src/x86_prologue_length_decoder_core_defines.svh
// assertion helpers shared by the decoder rtl
`ifndef X86_PROLOGUE_LENGTH_DECODER_CORE_DEFINES_SVH
`define X86_PROLOGUE_LENGTH_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define X86PLD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("x86pld assertion failed");
// next-cycle implication
`define X86PLD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("x86pld assertion failed");
`else
`define X86PLD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define X86PLD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: src/x86pld_pkg.sv
package x86pld_pkg;

   localparam int LEN_W = 6;
   localparam int TAIL_W = 4;
   localparam logic [LEN_W-1:0] MAX_WINDOW = 6'd48;
   localparam logic [LEN_W-1:0] REQ_LEN_RESET = 6'd14;

   // csr map
   localparam logic REG_REQUIRED_LENGTH = 1'b0;

   // opcode and prefix bytes
   localparam logic [7:0] OP_REX_LO      = 8'h40;
   localparam logic [7:0] OP_REX_HI      = 8'h4F;
   localparam logic [7:0] OP_OPSIZE      = 8'h66;
   localparam logic [7:0] OP_REPNE       = 8'hF2;
   localparam logic [7:0] OP_REP         = 8'hF3;
   localparam logic [7:0] OP_FS          = 8'h64;
   localparam logic [7:0] OP_GS          = 8'h65;
   localparam logic [7:0] OP_ADDRSIZE    = 8'h67;
   localparam logic [7:0] OP_PUSHPOP_LO  = 8'h50;
   localparam logic [7:0] OP_PUSHPOP_HI  = 8'h5F;
   localparam logic [7:0] OP_NOP         = 8'h90;
   localparam logic [7:0] OP_PUSH_IMM32  = 8'h68;
   localparam logic [7:0] OP_PUSH_IMM8   = 8'h6A;
   localparam logic [7:0] OP_MOV_IMM_LO  = 8'hB8;
   localparam logic [7:0] OP_MOV_IMM_HI  = 8'hBF;
   localparam logic [7:0] OP_MOV_RM8     = 8'h88;
   localparam logic [7:0] OP_MOV_RM      = 8'h89;
   localparam logic [7:0] OP_MOV_R8      = 8'h8A;
   localparam logic [7:0] OP_MOV_R       = 8'h8B;
   localparam logic [7:0] OP_LEA         = 8'h8D;
   localparam logic [7:0] OP_TEST        = 8'h85;
   localparam logic [7:0] OP_SUB_RM      = 8'h29;
   localparam logic [7:0] OP_SUB_R       = 8'h2B;
   localparam logic [7:0] OP_XOR_RM      = 8'h31;
   localparam logic [7:0] OP_XOR_R       = 8'h33;
   localparam logic [7:0] OP_CMP_RM      = 8'h39;
   localparam logic [7:0] OP_CMP_R       = 8'h3B;
   localparam logic [7:0] OP_GRP1_IMM8   = 8'h80;
   localparam logic [7:0] OP_GRP1_ALT    = 8'h82;
   localparam logic [7:0] OP_GRP1_SIMM8  = 8'h83;
   localparam logic [7:0] OP_MOV_RM8_IMM = 8'hC6;
   localparam logic [7:0] OP_GRP1_IMM32  = 8'h81;
   localparam logic [7:0] OP_MOV_RM_IMM  = 8'hC7;
   localparam logic [7:0] OP_ESCAPE      = 8'h0F;
   localparam logic [7:0] OP_NOPL        = 8'h1F;
   localparam logic [7:0] OP_ENDBR_2     = 8'h1E;
   localparam logic [7:0] OP_ENDBR_3     = 8'hFA;

   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REG      = 2'd3;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_DISP32    = 3'd5;

   typedef enum logic [1:0] {
      STATUS_SUCCESS = 2'd0,
      STATUS_UNSAFE  = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [LEN_W-1:0] length;
   } result_type;

endpackage

FILE: src/x86pld_csr.sv
module x86pld_csr
   import x86pld_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [LEN_W-1:0] required_length
);

   logic [LEN_W-1:0] req_len_ff;
   logic [LEN_W-1:0] req_len_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_REQUIRED_LENGTH);
   assign req_len_in = wr_hit ? pwdata[LEN_W-1:0] : req_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_len_ff <= REQ_LEN_RESET;
      end else begin
         req_len_ff <= req_len_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_REQUIRED_LENGTH) begin
         prdata = {{(32-LEN_W){1'b0}}, req_len_ff};
      end
   end

   assign required_length = req_len_ff;

endmodule

FILE: src/x86pld_decoder.sv
`include "x86_prologue_length_decoder_core_defines.svh"

module x86pld_decoder
   import x86pld_pkg::*;
#(
   parameter logic [LEN_W-1:0] WINDOW_LEN = MAX_WINDOW
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       code_byte,
   input  logic             last_byte,
   input  logic [LEN_W-1:0] required_length,
   output result_type       result
);

   typedef enum logic [5:0] {
      PH_PREFIX = 6'b000001,
      PH_ESC    = 6'b000010,
      PH_ENDBR  = 6'b000100,
      PH_MODRM  = 6'b001000,
      PH_SIB    = 6'b010000,
      PH_TAIL   = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      STEP_ON   = 2'd0,
      STEP_DONE = 2'd1,
      STEP_FAIL = 2'd2
   } step_type;

   phase_type         phase_ff, phase_in, phase_n;
   logic [LEN_W-1:0]  ib_ff, ib_in, ib_inc;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [TAIL_W-1:0] tail_ff, tail_in, tail_n;
   logic [TAIL_W-1:0] imm_ff, imm_in, imm_n;
   logic              rexw_ff, rexw_in, rexw_n;
   logic              f3_ff, f3_in, f3_n;
   logic              disc_ff, disc_in;
   step_type          step;
   logic [1:0]        mode;
   logic [2:0]        rm;
   logic [TAIL_W-1:0] disp;
   logic [TAIL_W-1:0] sib_base;
   logic [LEN_W:0]    sum;
   logic              emit;

   assign ib_inc = ib_ff + 6'd1;
   assign mode   = code_byte[7:6];
   assign rm     = code_byte[2:0];
   assign disp   = (mode == MOD_DISP8) ? 4'd1 : (mode == MOD_DISP32) ? 4'd4 : 4'd0;
   assign sib_base = (tail_ff == 4'd0 && rm == RM_DISP32) ? 4'd4 : tail_ff;
   assign sum    = {1'b0, total_ff} + {1'b0, ib_inc};

   // one byte through the instruction grammar
   always_comb begin
      step   = STEP_FAIL;
      phase_n = phase_ff;
      tail_n = tail_ff;
      imm_n  = imm_ff;
      rexw_n = rexw_ff;
      f3_n   = f3_ff;
      unique case (phase_ff)
         PH_PREFIX: begin
            unique case (code_byte) inside
               [OP_REX_LO:OP_REX_HI]: begin
                  step   = STEP_ON;
                  rexw_n = code_byte[3];
                  f3_n   = 1'b0;
               end
               OP_OPSIZE, OP_REPNE, OP_REP, OP_FS, OP_GS: begin
                  step   = STEP_ON;
                  rexw_n = 1'b0;
                  f3_n   = (code_byte == OP_REP) && (ib_inc == 6'd1);
               end
               OP_ADDRSIZE: step = STEP_FAIL;
               [OP_PUSHPOP_LO:OP_PUSHPOP_HI], OP_NOP: step = STEP_DONE;
               OP_PUSH_IMM32: begin
                  step = STEP_ON; tail_n = 4'd4; phase_n = PH_TAIL;
               end
               OP_PUSH_IMM8: begin
                  step = STEP_ON; tail_n = 4'd1; phase_n = PH_TAIL;
               end
               [OP_MOV_IMM_LO:OP_MOV_IMM_HI]: begin
                  step = STEP_ON; tail_n = rexw_ff ? 4'd8 : 4'd4; phase_n = PH_TAIL;
               end
               OP_MOV_RM8, OP_MOV_RM, OP_MOV_R8, OP_MOV_R, OP_LEA, OP_TEST,
               OP_SUB_RM, OP_SUB_R, OP_XOR_RM, OP_XOR_R, OP_CMP_RM, OP_CMP_R: begin
                  step = STEP_ON; imm_n = 4'd0; phase_n = PH_MODRM;
               end
               OP_GRP1_IMM8, OP_GRP1_ALT, OP_GRP1_SIMM8, OP_MOV_RM8_IMM: begin
                  step = STEP_ON; imm_n = 4'd1; phase_n = PH_MODRM;
               end
               OP_GRP1_IMM32, OP_MOV_RM_IMM: begin
                  step = STEP_ON; imm_n = 4'd4; phase_n = PH_MODRM;
               end
               OP_ESCAPE: begin
                  step = STEP_ON; phase_n = PH_ESC;
               end
               default: step = STEP_FAIL;
            endcase
         end
         PH_ESC: begin
            if (code_byte == OP_NOPL) begin
               step = STEP_ON; imm_n = 4'd0; phase_n = PH_MODRM;
            end else if (code_byte == OP_ENDBR_2 && f3_ff && ib_inc == 6'd3) begin
               step = STEP_ON; phase_n = PH_ENDBR;
            end
         end
         PH_ENDBR: begin
            step = (code_byte == OP_ENDBR_3) ? STEP_DONE : STEP_FAIL;
         end
         PH_MODRM: begin
            if (mode == MOD_REG) begin
               tail_n = imm_ff;
               step = (imm_ff == 4'd0) ? STEP_DONE : STEP_ON;
               phase_n = PH_TAIL;
            end else if (rm == RM_SIB) begin
               tail_n = disp; step = STEP_ON; phase_n = PH_SIB;
            end else if (mode == MOD_INDIRECT && rm == RM_DISP32) begin
               // rip-relative
               step = STEP_FAIL;
            end else begin
               tail_n = disp + imm_ff;
               step = (tail_n == 4'd0) ? STEP_DONE : STEP_ON;
               phase_n = PH_TAIL;
            end
         end
         PH_SIB: begin
            tail_n = sib_base + imm_ff;
            step = (tail_n == 4'd0) ? STEP_DONE : STEP_ON;
            phase_n = PH_TAIL;
         end
         PH_TAIL: begin
            tail_n = (tail_ff != 4'd0) ? tail_ff - 4'd1 : 4'd0;
            step = (tail_n == 4'd0) ? STEP_DONE : STEP_ON;
         end
         default: step = STEP_FAIL;
      endcase
   end

   // result and next decoder state
   always_comb begin
      phase_in = phase_ff;
      ib_in    = ib_ff;
      total_in = total_ff;
      tail_in  = tail_ff;
      imm_in   = imm_ff;
      rexw_in  = rexw_ff;
      f3_in    = f3_ff;
      disc_in  = disc_ff;
      emit     = 1'b0;
      result.valid  = 1'b0;
      result.status = STATUS_SUCCESS;
      result.length = '0;
      if (fire) begin
         if (disc_ff) begin
            if (last_byte) begin
               disc_in = 1'b0;
            end
         end else if (total_ff >= required_length) begin
            emit = 1'b1;
            result.length = total_ff;
         end else if (step == STEP_FAIL) begin
            emit = 1'b1;
            result.status = STATUS_UNSAFE;
         end else if (step == STEP_DONE) begin
            if (sum >= {1'b0, required_length}) begin
               emit = 1'b1;
               result.length = sum[LEN_W-1:0];
            end else if (last_byte || sum >= {1'b0, WINDOW_LEN}) begin
               emit = 1'b1;
               result.status = STATUS_SHORT;
            end else begin
               total_in = sum[LEN_W-1:0];
               phase_in = PH_PREFIX;
               ib_in    = '0;
               tail_in  = '0;
               imm_in   = '0;
               rexw_in  = 1'b0;
               f3_in    = 1'b0;
            end
         end else begin
            if (last_byte || sum >= {1'b0, WINDOW_LEN}) begin
               emit = 1'b1;
               result.status = STATUS_UNSAFE;
            end else begin
               ib_in    = ib_inc;
               phase_in = phase_n;
               tail_in  = tail_n;
               imm_in   = imm_n;
               rexw_in  = rexw_n;
               f3_in    = f3_n;
            end
         end
         if (emit) begin
            result.valid = 1'b1;
            phase_in = PH_PREFIX;
            ib_in    = '0;
            total_in = '0;
            tail_in  = '0;
            imm_in   = '0;
            rexw_in  = 1'b0;
            f3_in    = 1'b0;
            disc_in  = !last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         ib_ff    <= '0;
         total_ff <= '0;
         tail_ff  <= '0;
         imm_ff   <= '0;
         rexw_ff  <= 1'b0;
         f3_ff    <= 1'b0;
         disc_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ib_ff    <= ib_in;
         total_ff <= total_in;
         tail_ff  <= tail_in;
         imm_ff   <= imm_in;
         rexw_ff  <= rexw_in;
         f3_ff    <= f3_in;
         disc_ff  <= disc_in;
      end
   end

   `X86PLD_ASSERT_IMP(a_disc_quiet, clock, reset, disc_ff, !result.valid)
   `X86PLD_ASSERT_NXT(a_disc_after_result, clock, reset, result.valid && !last_byte, disc_ff)
   `X86PLD_ASSERT_IMP(a_fail_len_zero, clock, reset,
                      result.valid && result.status != STATUS_SUCCESS, result.length == '0)
   `X86PLD_ASSERT_IMP(a_tail_bound, clock, reset, 1'b1, tail_ff <= 4'd8)

endmodule

FILE: src/x86_prologue_length_decoder_core.sv
// x86-64 prologue length decoder. Code bytes of one function arrive one per req
// transfer, the final available byte flagged by req_last_byte. The block walks
// instruction boundaries over a safe subset (endbr64, prefixes, push/pop/nop,
// push/mov immediates, listed modrm forms, 0f 1f nop) and returns one rsp
// transfer per function: success with the whole-instruction byte count once it
// reaches required_length, unsafe on an unknown or rip-relative form or an
// instruction cut at the last byte or the window end (WINDOW_LEN, 48 bytes by
// default), or too short when the input or the window ends on a boundary below
// the requirement. Bytes after a result are dropped up to and including the
// next byte marked last. Throughput is one byte per clock while rsp is not
// stalled, set by the byte decode loop; a result is registered on rsp as the
// byte that causes it leaves the input register. required_length sits at csr
// byte address 0 and should be written only while the block is idle.
module x86_prologue_length_decoder_core
   import x86pld_pkg::*;
#(
   parameter logic [LEN_W-1:0] WINDOW_LEN = MAX_WINDOW
)
(
   input  logic             clock,
   input  logic             reset,
   // byte input channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_code_byte,
   input  logic             req_last_byte,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [LEN_W-1:0] rsp_patch_length,
   // configuration port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   `include "x86_prologue_length_decoder_core_defines.svh"

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff, s1_byte_in;
   logic             s1_last_ff, s1_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0] required_length;
   logic             out_busy;
   logic             advance;
   logic             req_xfer;
   result_type       result;

   // output register full and held by the consumer
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign advance  = !out_busy;
   // input register takes a byte unless it holds one that cannot move on
   assign req_stall = s1_valid_ff && out_busy;
   assign req_xfer  = req_valid && !req_stall;

   x86pld_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .required_length (required_length)
   );

   // per-byte decode, state updated as the byte leaves the input register
   x86pld_decoder #(
      .WINDOW_LEN      (WINDOW_LEN)
   ) u_decoder (
      .clock           (clock),
      .reset           (reset),
      .fire            (s1_valid_ff && advance),
      .code_byte       (s1_byte_ff),
      .last_byte       (s1_last_ff),
      .required_length (required_length),
      .result          (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_code_byte;
         s1_last_in  = req_last_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_status_in = result.status;
            rsp_len_in    = result.length;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_last_ff    <= s1_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_patch_length = rsp_len_ff;

   // a byte held in the input register is never lost while the output is blocked
   `X86PLD_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && out_busy, s1_valid_ff)

endmodule
